[design/assert_macros.svh]
// Concurrent assertion wrappers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CFMF_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("cidr filter check failed");
`define CFMF_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
	else $error("cidr filter check failed");
`else
`define CFMF_ASSERT(name, clk, rst_n, prop)
`define CFMF_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

[design/cfmf_pkg.sv]
package cfmf_pkg;

	localparam int ADDR_W  = 32;
	localparam int PLEN_W  = 6;
	localparam int HIDX_W  = 4;

	localparam logic [PLEN_W-1:0] PLEN_MAX = 6'd32;

	localparam logic OP_ADD    = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic              valid;
		logic              op;
		logic [ADDR_W-1:0] address;
		logic [PLEN_W-1:0] prefix_len;
		logic              rule_allow;
		logic              add_ok;
		logic              hit;
		logic              permitted;
		logic [HIDX_W-1:0] hit_index;
	} token_t;

	function automatic logic [ADDR_W-1:0] prefix_mask(input logic [PLEN_W-1:0] plen);
		logic [ADDR_W-1:0] m;
		if (plen == '0) begin
			m = '0;
		end else if (plen >= PLEN_MAX) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (PLEN_MAX - plen);
		end
		return m;
	endfunction

endpackage

[design/cfmf_cell.sv]
module cfmf_cell #(
	parameter int INDEX = 0,
	parameter int CNT_W = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfmf_pkg::token_t  tok_i,
	input  logic [CNT_W-1:0]  cnt_i,
	output cfmf_pkg::token_t  tok_o,
	output logic [CNT_W-1:0]  cnt_o
);
	import cfmf_pkg::*;

	localparam logic [CNT_W-1:0]  IDX_C  = CNT_W'(INDEX);
	localparam logic [HIDX_W-1:0] HIDX_C = HIDX_W'(INDEX);

	logic [ADDR_W-1:0] net_q;
	logic [PLEN_W-1:0] plen_q;
	logic              mode_q;

	token_t           tok_s1;
	logic [CNT_W-1:0] cnt_s1;
	token_t           tok_nx;
	logic             wr_en;
	logic             match;

	assign wr_en = tok_i.valid && (tok_i.op == OP_ADD) && tok_i.add_ok && (cnt_i == IDX_C);

	assign match = tok_i.valid && (tok_i.op == OP_LOOKUP) && !tok_i.hit
		&& (cnt_i > IDX_C)
		&& (((net_q ^ tok_i.address) & prefix_mask(plen_q)) == '0);

	always_comb begin
		tok_nx = tok_i;
		if (match) begin
			tok_nx.hit       = 1'b1;
			tok_nx.permitted = mode_q;
			tok_nx.hit_index = HIDX_C;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			net_q  <= tok_i.address;
			plen_q <= tok_i.prefix_len;
			mode_q <= tok_i.rule_allow;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			cnt_s1 <= '0;
		end else begin
			tok_s1 <= tok_nx;
			cnt_s1 <= cnt_i;
		end
	end

	assign tok_o = tok_s1;
	assign cnt_o = cnt_s1;

endmodule

[design/cidr_first_match_filter.sv]
// Channel   Signals                                         Handshake
// input     op, address, prefix_len, rule_allow             start && !busy
// result    permitted, hit, hit_index, add_rejected         done, one cycle, no stall
//
// One item enters per cycle; busy stays low.
// Each item walks the rule chain one cell per cycle, registered in every cell;
// its result appears on done after the last cell, in order.
// Reset clears the rule count and the chain's valid flags; rule cells hold
// no reset value and are written only by accepted adds.
// The receiver cannot stall: each result is shown for one cycle only.
`include "assert_macros.svh"

module cidr_first_match_filter #(
	parameter int MAX_RULES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [cfmf_pkg::ADDR_W-1:0]    address,
	input  logic [cfmf_pkg::PLEN_W-1:0]    prefix_len,
	input  logic                           rule_allow,
	output logic                           done,
	output logic                           permitted,
	output logic                           hit,
	output logic [cfmf_pkg::HIDX_W-1:0]    hit_index,
	output logic                           add_rejected
);
	import cfmf_pkg::*;

	localparam int CNT_W = $clog2(MAX_RULES + 1);
	localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_RULES);

	logic [CNT_W-1:0] count_q;
	logic             accept;
	logic             add_ok;

	token_t           tok [MAX_RULES+1];
	logic [CNT_W-1:0] cnt [MAX_RULES+1];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign add_ok = (count_q < FULL_C) && (prefix_len <= PLEN_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && (op == OP_ADD) && add_ok) begin
			count_q <= count_q + 1'b1;
		end
	end

	assign tok[0] = '{
		valid:      accept,
		op:         op,
		address:    address,
		prefix_len: prefix_len,
		rule_allow: rule_allow,
		add_ok:     add_ok,
		hit:        1'b0,
		permitted:  1'b0,
		hit_index:  '0
	};
	assign cnt[0] = count_q;

	for (genvar i = 0; i < MAX_RULES; i++) begin : g_cell
		cfmf_cell #(
			.INDEX (i),
			.CNT_W (CNT_W)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_i  (tok[i]),
			.cnt_i  (cnt[i]),
			.tok_o  (tok[i+1]),
			.cnt_o  (cnt[i+1])
		);
	end

	assign done         = tok[MAX_RULES].valid;
	assign permitted    = tok[MAX_RULES].permitted;
	assign hit          = tok[MAX_RULES].hit;
	assign hit_index    = tok[MAX_RULES].hit_index;
	assign add_rejected = (tok[MAX_RULES].op == OP_ADD) && !tok[MAX_RULES].add_ok;

	`CFMF_ASSERT(a_count_bound, clk, arst_n, count_q <= FULL_C)
	`CFMF_ASSERT(a_add_grows, clk, arst_n, accept && (op == OP_ADD) && add_ok |=> count_q == $past(count_q) + 1'b1)
	`CFMF_ASSERT(a_lookup_keeps, clk, arst_n, accept && (op == OP_LOOKUP) |=> $stable(count_q))
	`CFMF_ASSERT(a_latency, clk, arst_n, done |-> $past(accept, MAX_RULES))
	`CFMF_ASSERT(a_add_no_hit, clk, arst_n, done && add_rejected |-> !hit && !permitted)
	`CFMF_ASSERT(a_default_deny, clk, arst_n, done && !hit |-> !permitted && (hit_index == '0))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import cfmf_pkg::*;

	localparam int N_RULES = 16;
	localparam int N_RANDOM = 700;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic              permitted;
		logic              hit;
		logic [HIDX_W-1:0] hit_index;
		logic              add_rejected;
	} verdict_t;

	typedef struct packed {
		logic              op;
		logic [ADDR_W-1:0] addr;
		logic [PLEN_W-1:0] plen;
		logic              allow;
		logic              typed;
		verdict_t          want;
	} acl_row_t;

	localparam verdict_t V_NONE = '{1'b0, 1'b0, 4'd0, 1'b0};
	localparam verdict_t V_REJ  = '{1'b0, 1'b0, 4'd0, 1'b1};

	localparam int N_DIR = 25;
	localparam acl_row_t ACL_TAB [0:N_DIR-1] = '{
		'{OP_LOOKUP, 32'hFFFFFFFF, 6'd63, 1'b1, 1'b1, V_NONE},
		'{OP_LOOKUP, 32'h00000000, 6'd0,  1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'hC0A80000, 6'd33, 1'b1, 1'b1, V_REJ},
		'{OP_ADD,    32'hFFFFFFFF, 6'd63, 1'b1, 1'b1, V_REJ},
		'{OP_ADD,    32'hC0A80000, 6'd16, 1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'hFFFFFFFF, 6'd32, 1'b0, 1'b1, V_NONE},
		'{OP_LOOKUP, 32'hC0A8FFFF, 6'd0,  1'b0, 1'b0, V_NONE},
		'{OP_LOOKUP, 32'hFFFFFFFF, 6'd0,  1'b0, 1'b0, V_NONE},
		'{OP_LOOKUP, 32'hFFFFFFFE, 6'd32, 1'b1, 1'b0, V_NONE},
		'{OP_ADD,    32'h0A000000, 6'd8,  1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h0A010000, 6'd16, 1'b1, 1'b1, V_NONE},
		'{OP_LOOKUP, 32'h0A010203, 6'd5,  1'b1, 1'b0, V_NONE},
		'{OP_ADD,    32'hAC100000, 6'd12, 1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'h00000000, 6'd32, 1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'h55555555, 6'd31, 1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'hAAAAAAAA, 6'd24, 1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'hC0A80100, 6'd24, 1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h12345678, 6'd20, 1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h80000000, 6'd2,  1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'hFEDCBA98, 6'd28, 1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h0F0F0F0F, 6'd4,  1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'hF0000000, 6'd5,  1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h66666666, 6'd17, 1'b1, 1'b1, V_NONE},
		'{OP_ADD,    32'h00000000, 6'd0,  1'b0, 1'b1, V_NONE},
		'{OP_ADD,    32'h01020304, 6'd32, 1'b1, 1'b1, V_REJ}
	};

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic              op = OP_ADD;
	logic [ADDR_W-1:0] address = '0;
	logic [PLEN_W-1:0] prefix_len = '0;
	logic              rule_allow = 1'b0;
	logic              done;
	logic              permitted;
	logic              hit;
	logic [HIDX_W-1:0] hit_index;
	logic              add_rejected;

	logic [ADDR_W-1:0] rule_net [N_RULES];
	logic [PLEN_W-1:0] rule_len [N_RULES];
	logic              rule_act [N_RULES];
	int                rule_cnt = 0;

	verdict_t verdict_q [$];
	verdict_t got_want;
	int       errors = 0;
	int       cycles = 0;
	int       n_items = 0;
	int       n_lookups = 0;
	int       n_hits = 0;
	int       n_refused = 0;
	bit       idle_on = 1'b1;

	cidr_first_match_filter #(
		.MAX_RULES(N_RULES)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.address(address),
		.prefix_len(prefix_len),
		.rule_allow(rule_allow),
		.done(done),
		.permitted(permitted),
		.hit(hit),
		.hit_index(hit_index),
		.add_rejected(add_rejected)
	);

	always #5 clk = ~clk;

	function automatic logic [ADDR_W-1:0] cidr_mask(input logic [PLEN_W-1:0] pl);
		if (pl == 6'd0) begin
			return '0;
		end else if (pl >= 6'd32) begin
			return '1;
		end
		return {ADDR_W{1'b1}} << (32 - pl);
	endfunction

	task automatic classify(input logic o, input logic [ADDR_W-1:0] a,
			input logic [PLEN_W-1:0] pl, input logic al, output verdict_t v);
		logic [ADDR_W-1:0] m;
		bit found;
		v = '0;
		found = 1'b0;
		if (o == OP_ADD) begin
			if (rule_cnt >= N_RULES || pl > 6'd32) begin
				v.add_rejected = 1'b1;
			end else begin
				rule_net[rule_cnt] = a;
				rule_len[rule_cnt] = pl;
				rule_act[rule_cnt] = al;
				rule_cnt++;
			end
		end else begin
			for (int k = 0; k < rule_cnt; k++) begin
				m = cidr_mask(rule_len[k]);
				if (!found && (rule_net[k] & m) == (a & m)) begin
					found = 1'b1;
					v.hit = 1'b1;
					v.hit_index = k[HIDX_W-1:0];
					v.permitted = rule_act[k];
				end
			end
		end
	endtask

	task automatic send_item(input logic o, input logic [ADDR_W-1:0] a,
			input logic [PLEN_W-1:0] pl, input logic al,
			input logic typed, input verdict_t want);
		verdict_t pred;
		while (idle_on && $urandom_range(0, 99) < 19) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		address <= a;
		prefix_len <= pl;
		rule_allow <= al;
		do @(posedge clk); while (busy);
		classify(o, a, pl, al, pred);
		n_items++;
		if (o == OP_LOOKUP) begin
			n_lookups++;
			n_hits += pred.hit;
		end
		n_refused += pred.add_rejected;
		verdict_q.push_back(typed ? want : pred);
	endtask

	task automatic drain_results;
		start <= 1'b0;
		do @(posedge clk); while (verdict_q.size() != 0);
	endtask

	task automatic report(input string what, input int got, input int want);
		$display("mismatch at cycle %0d: %s got %0d want %0d", cycles, what, got, want);
		errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (verdict_q.size() == 0) begin
				report("result with no item pending, add_rejected", add_rejected, 0);
			end else begin
				got_want = verdict_q.pop_front();
				if (permitted !== got_want.permitted)
					report("permitted", permitted, got_want.permitted);
				if (hit !== got_want.hit)
					report("hit", hit, got_want.hit);
				if (hit_index !== got_want.hit_index)
					report("hit_index", hit_index, got_want.hit_index);
				if (add_rejected !== got_want.add_rejected)
					report("add_rejected", add_rejected, got_want.add_rejected);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				verdict_q.size());
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		logic              r_op;
		logic [ADDR_W-1:0] r_addr;
		logic [ADDR_W-1:0] m;
		logic [PLEN_W-1:0] r_len;
		int                k;
		int                pick;

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			send_item(ACL_TAB[i].op, ACL_TAB[i].addr, ACL_TAB[i].plen, ACL_TAB[i].allow,
				ACL_TAB[i].typed, ACL_TAB[i].want);
		end
		drain_results();

		for (int n = 0; n < N_RANDOM; n++) begin
			idle_on = !(n >= 250 && n < 420);
			if (n == 500)
				drain_results();
			r_op = ($urandom_range(0, 99) < 70) ? OP_LOOKUP : OP_ADD;
			r_len = PLEN_W'($urandom_range(0, 63));
			r_addr = $urandom;
			if (r_op == OP_LOOKUP && rule_cnt > 0) begin
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					k = $urandom_range(0, rule_cnt - 1);
					m = cidr_mask(rule_len[k]);
					r_addr = (rule_net[k] & m) | ($urandom & ~m);
					if (pick >= 50 && rule_len[k] != 6'd0)
						r_addr ^= 32'h1 << (32 - $urandom_range(1, rule_len[k]));
				end
			end
			send_item(r_op, r_addr, r_len, 1'($urandom_range(0, 1)), 1'b0, V_NONE);
		end

		drain_results();
		repeat (2 * N_RULES + 4) @(posedge clk);

		$display("%0d items: %0d lookups with %0d rule hits, %0d adds refused",
			n_items, n_lookups, n_hits, n_refused);
		$display("table filled to %0d rules, %0d mismatches", rule_cnt, errors);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
